// ===== rtl/ncb_pkg.sv =====
// ----------------------------------------------------------------------------
// ncb_pkg
// Shared types for the necklace counter: beat payloads, microcode word,
// datapath status flags and program step addresses.
// ----------------------------------------------------------------------------
`default_nettype none

package ncb_pkg;

  typedef struct packed {
    logic [7:0]  pearl_count;
    logic [15:0] color_count;
  } in_t;

  typedef struct packed {
    logic [63:0] necklace_count;
    logic        overflow;
  } out_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_GINIT,
    OP_GSUB,
    OP_PINIT,
    OP_PMUL,
    OP_ADD,
    OP_DINIT,
    OP_DSTEP,
    OP_EMIT
  } op_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IDLE,
    C_NZERO,
    C_GNE,
    C_PMORE,
    C_OVF,
    C_KMORE,
    C_DMORE
  } cond_t;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic n_zero;
    logic g_ne;
    logic p_more;
    logic ovf;
    logic k_more;
    logic d_more;
  } status_t;

  // program step addresses
  localparam upc_t ST_WAIT  = 4'd0;
  localparam upc_t ST_CHKN  = 4'd1;
  localparam upc_t ST_GINIT = 4'd2;
  localparam upc_t ST_GSUB  = 4'd3;
  localparam upc_t ST_PINIT = 4'd4;
  localparam upc_t ST_PMUL  = 4'd5;
  localparam upc_t ST_ADD   = 4'd6;
  localparam upc_t ST_KLOOP = 4'd7;
  localparam upc_t ST_CHKO  = 4'd8;
  localparam upc_t ST_DINIT = 4'd9;
  localparam upc_t ST_DSTEP = 4'd10;
  localparam upc_t ST_EMIT  = 4'd11;

endpackage

`default_nettype wire

// ===== rtl/ncb_urom.sv =====
// ----------------------------------------------------------------------------
// ncb_urom
// Microcode ROM: one control word per program step.
// ----------------------------------------------------------------------------
`default_nettype none

module ncb_urom (
  input  ncb_pkg::upc_t   addr,
  output ncb_pkg::uword_t word
);

  always_comb begin
    case (addr)
      ncb_pkg::ST_WAIT:  word = '{ncb_pkg::OP_NOP,   ncb_pkg::C_IDLE,   ncb_pkg::ST_WAIT};
      ncb_pkg::ST_CHKN:  word = '{ncb_pkg::OP_NOP,   ncb_pkg::C_NZERO,  ncb_pkg::ST_EMIT};
      ncb_pkg::ST_GINIT: word = '{ncb_pkg::OP_GINIT, ncb_pkg::C_NEVER,  ncb_pkg::ST_WAIT};
      ncb_pkg::ST_GSUB:  word = '{ncb_pkg::OP_GSUB,  ncb_pkg::C_GNE,    ncb_pkg::ST_GSUB};
      ncb_pkg::ST_PINIT: word = '{ncb_pkg::OP_PINIT, ncb_pkg::C_NEVER,  ncb_pkg::ST_WAIT};
      ncb_pkg::ST_PMUL:  word = '{ncb_pkg::OP_PMUL,  ncb_pkg::C_PMORE,  ncb_pkg::ST_PMUL};
      ncb_pkg::ST_ADD:   word = '{ncb_pkg::OP_ADD,   ncb_pkg::C_OVF,    ncb_pkg::ST_EMIT};
      ncb_pkg::ST_KLOOP: word = '{ncb_pkg::OP_NOP,   ncb_pkg::C_KMORE,  ncb_pkg::ST_GINIT};
      ncb_pkg::ST_CHKO:  word = '{ncb_pkg::OP_NOP,   ncb_pkg::C_OVF,    ncb_pkg::ST_EMIT};
      ncb_pkg::ST_DINIT: word = '{ncb_pkg::OP_DINIT, ncb_pkg::C_NEVER,  ncb_pkg::ST_WAIT};
      ncb_pkg::ST_DSTEP: word = '{ncb_pkg::OP_DSTEP, ncb_pkg::C_DMORE,  ncb_pkg::ST_DSTEP};
      ncb_pkg::ST_EMIT:  word = '{ncb_pkg::OP_EMIT,  ncb_pkg::C_ALWAYS, ncb_pkg::ST_WAIT};
      default:           word = '{ncb_pkg::OP_NOP,   ncb_pkg::C_ALWAYS, ncb_pkg::ST_WAIT};
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ncb_seq.sv =====
// ----------------------------------------------------------------------------
// ncb_seq
// Step counter with conditional jumps; fetches the control word.
// ----------------------------------------------------------------------------
`default_nettype none

module ncb_seq (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  ncb_pkg::status_t stat,
  output ncb_pkg::uword_t  word,
  output logic             busy
);

  ncb_pkg::upc_t upc_r;
  ncb_pkg::upc_t upc_nxt;
  logic          take;

  ncb_urom u_urom (
    .addr (upc_r),
    .word (word)
  );

  always_comb begin
    case (word.cond)
      ncb_pkg::C_NEVER:  take = 1'b0;
      ncb_pkg::C_ALWAYS: take = 1'b1;
      ncb_pkg::C_IDLE:   take = !start;
      ncb_pkg::C_NZERO:  take = stat.n_zero;
      ncb_pkg::C_GNE:    take = stat.g_ne;
      ncb_pkg::C_PMORE:  take = stat.p_more;
      ncb_pkg::C_OVF:    take = stat.ovf;
      ncb_pkg::C_KMORE:  take = stat.k_more;
      ncb_pkg::C_DMORE:  take = stat.d_more;
      default:           take = 1'b0;
    endcase
    upc_nxt = take ? word.target : ncb_pkg::upc_t'(upc_r + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ncb_pkg::ST_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign busy = (upc_r != ncb_pkg::ST_WAIT);

endmodule

`default_nettype wire

// ===== rtl/ncb_datapath.sv =====
// ----------------------------------------------------------------------------
// ncb_datapath
// Registers and units driven by the control word: subtractive gcd,
// bounded power by repeated multiply, saturating sum, bit-serial divide.
// ----------------------------------------------------------------------------
`default_nettype none

module ncb_datapath #(
  parameter int RESULT_WIDTH = 64
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              load,
  input  ncb_pkg::in_t     in_data,
  input  ncb_pkg::uword_t  word,
  output ncb_pkg::status_t stat,
  output ncb_pkg::out_t    out_data,
  output logic             out_valid
);

  localparam int RW = RESULT_WIDTH;
  localparam int CW = $clog2(RW + 1);
  localparam logic [RW-1:0] LIM = {RW{1'b1}};

  logic [7:0]    n_r, k_r, ga_r, gb_r, e_r;
  logic [15:0]   m_r;
  logic [RW-1:0] acc_r, sum_r;
  logic [8:0]    rem_r;
  logic [CW-1:0] cnt_r;
  logic          ovf_r;
  logic          out_valid_r;
  ncb_pkg::out_t out_r;

  logic [RW+15:0] prod;
  logic           prod_ovf;
  logic [RW:0]    sum_ext;
  logic [8:0]     shifted;
  logic [9:0]     trial;

  assign prod     = (RW+16)'(acc_r) * (RW+16)'(m_r);
  assign prod_ovf = |prod[RW+15:RW];
  assign sum_ext  = {1'b0, sum_r} + {1'b0, acc_r};
  assign shifted  = {rem_r[7:0], sum_r[RW-1]};
  assign trial    = {1'b0, shifted} - {2'b00, n_r};

  assign stat.n_zero = (n_r == 8'd0);
  assign stat.g_ne   = (ga_r != gb_r);
  assign stat.p_more = (e_r > 8'd1) && !prod_ovf;
  assign stat.ovf    = ovf_r;
  assign stat.k_more = (k_r != n_r) && !ovf_r;
  assign stat.d_more = (cnt_r != CW'(1));

  always_ff @(posedge clk) begin
    if (load) begin
      n_r   <= in_data.pearl_count;
      m_r   <= in_data.color_count;
      k_r   <= 8'd0;
      sum_r <= '0;
    end else begin
      case (word.op)
        ncb_pkg::OP_GINIT: begin
          ga_r <= n_r;
          gb_r <= (k_r == 8'd0) ? n_r : k_r;
        end
        ncb_pkg::OP_GSUB: begin
          if (ga_r > gb_r) begin
            ga_r <= ga_r - gb_r;
          end else if (gb_r > ga_r) begin
            gb_r <= gb_r - ga_r;
          end
        end
        ncb_pkg::OP_PINIT: begin
          acc_r <= RW'(1);
          e_r   <= (m_r <= 16'd1) ? 8'd1 : ga_r;
        end
        ncb_pkg::OP_PMUL: begin
          if (!prod_ovf) begin
            acc_r <= prod[RW-1:0];
          end
          e_r <= e_r - 8'd1;
        end
        ncb_pkg::OP_ADD: begin
          if (!ovf_r && !sum_ext[RW]) begin
            sum_r <= sum_ext[RW-1:0];
          end
          k_r <= k_r + 8'd1;
        end
        ncb_pkg::OP_DINIT: begin
          rem_r <= 9'd0;
          cnt_r <= CW'(RW);
        end
        ncb_pkg::OP_DSTEP: begin
          if (!trial[9]) begin
            rem_r <= trial[8:0];
            sum_r <= {sum_r[RW-2:0], 1'b1};
          end else begin
            rem_r <= shifted;
            sum_r <= {sum_r[RW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - CW'(1);
        end
        ncb_pkg::OP_EMIT: begin
          out_r.necklace_count <= 64'(ovf_r ? LIM : sum_r);
          out_r.overflow       <= ovf_r;
        end
        default: begin
        end
      endcase
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (word.op == ncb_pkg::OP_EMIT) && !load;
      if (load) begin
        ovf_r <= 1'b0;
      end else if (word.op == ncb_pkg::OP_PMUL && prod_ovf) begin
        ovf_r <= 1'b1;
      end else if (word.op == ncb_pkg::OP_ADD && !ovf_r && sum_ext[RW]) begin
        ovf_r <= 1'b1;
      end
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/necklace_count_burnside.sv =====
// Overflow ends the loop at once and skips the divide; n = 0 goes straight to the result step.
// Throughput: one item at a time, one multiply or subtract per microcode step; busy is
//   high after the accept beat and low again on the result beat.
// Reset: synchronous active-low rst_n returns the step counter to its wait step, no result.
// ----------------------------------------------------------------------------
// necklace_count_burnside
// Burnside necklace counter: sum of m^gcd(k,n) over rotations, divided by n,
// with overflow saturation at RESULT_WIDTH bits. Microcoded sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module necklace_count_burnside #(
  parameter int RESULT_WIDTH = 64
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           start,
  output logic          busy,
  input  ncb_pkg::in_t  in_data,
  output logic          out_valid,
  output ncb_pkg::out_t out_data
);

  ncb_pkg::uword_t  word;
  ncb_pkg::status_t stat;
  logic             load;

  // input beat taken only at the wait step
  assign load = start && !busy;

  // step counter, ROM and jump logic
  ncb_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .word  (word),
    .busy  (busy)
  );

  // gcd, power, sum and divide registers
  ncb_datapath #(
    .RESULT_WIDTH (RESULT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .in_data   (in_data),
    .word      (word),
    .stat      (stat),
    .out_data  (out_data),
    .out_valid (out_valid)
  );

`ifndef SYNTHESIS
  // a result beat only follows a running program
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a running item");

  // sequencer is back at the wait step when the result is shown
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // an accepted beat starts the program
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accept did not start the sequencer");

  // overflow saturates the count
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overflow) |->
      (out_data.necklace_count == 64'({RESULT_WIDTH{1'b1}})))
    else $error("overflow without saturated count");
`endif

endmodule

`default_nettype wire

// ===== bench/necklace_count_burnside_test.sv =====
// ----------------------------------------------------------------------------
// necklace_count_burnside_test
// Self-checking bench for the Burnside necklace counter. Queries go in over
// the start/busy command port; a local predictor works out the rotation-class
// count (with saturation on overflow) for each accepted query, and every
// strobed result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module necklace_count_burnside_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNT_WIDTH = 64;

  // Slowest query: n = 255 with m <= 1, which runs every rotation and the divide.
  // Directed and random parts hold under ten of those; every other query is
  // far shorter, plus sender gaps. This limit is several times the slowest
  // correct run.
  localparam int unsigned CYCLE_LIMIT = 8_000_000;

  // After the last result, the longest a stray beat could still take to show
  // up is about one short query's latency.
  localparam int unsigned TAIL_CYCLES = 300;

  typedef struct {
    ncb_pkg::in_t  query;
    ncb_pkg::out_t answer;
  } pending_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts each accepted query, checks each result beat in order.
  // --------------------------------------------------------------------------
  class necklace_tally;
    pending_t    pending_counts[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    static function int unsigned gcd_of(int unsigned a, int unsigned b);
      int unsigned t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    // {saturated, base^expo}; saturated value is lim
    static function logic [64:0] capped_power(longint unsigned base, int unsigned expo,
                                              longint unsigned lim);
      logic [127:0]    prod;
      longint unsigned acc;
      int unsigned     i;
      if (expo == 0) return {1'b0, 64'd1};
      if (base <= 1) return {1'b0, base};
      acc = 64'd1;
      for (i = 0; i < expo; i++) begin
        prod = 128'(acc) * 128'(base);
        if (prod > 128'(lim)) return {1'b1, lim};
        acc = prod[63:0];
      end
      return {1'b0, acc};
    endfunction

    static function ncb_pkg::out_t count_necklaces(ncb_pkg::in_t q);
      longint unsigned lim;
      longint unsigned total;
      longint unsigned m;
      int unsigned     n;
      int unsigned     k;
      int unsigned     g;
      logic [64:0]     term;
      logic            sat;
      ncb_pkg::out_t   res;
      lim   = (COUNT_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << COUNT_WIDTH) - 64'd1);
      n     = 32'(q.pearl_count);
      m     = 64'(q.color_count);
      total = 64'd0;
      sat   = 1'b0;
      if (n == 0) begin
        res.necklace_count = '0;
        res.overflow       = 1'b0;
        return res;
      end
      for (k = 0; k < n && !sat; k++) begin
        g    = (k == 0) ? n : gcd_of(k, n);
        term = capped_power(m, g, lim);
        if (term[64])
          sat = 1'b1;
        else if (total > lim - term[63:0])
          sat = 1'b1;
        else
          total += term[63:0];
      end
      res.necklace_count = sat ? lim : total / 64'(n);
      res.overflow       = sat;
      return res;
    endfunction

    function void note_query(ncb_pkg::in_t q);
      pending_t p;
      p.query  = q;
      p.answer = count_necklaces(q);
      pending_counts.push_back(p);
    endfunction

    function void check_answer(ncb_pkg::out_t got);
      pending_t p;
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected result beat: count=%0d overflow=%0b",
                 $time, got.necklace_count, got.overflow);
        errors++;
        return;
      end
      p = pending_counts.pop_front();
      if (got.necklace_count !== p.answer.necklace_count) begin
        $display("%0t: n=%0d m=%0d necklace_count expected %0d actual %0d", $time,
                 p.query.pearl_count, p.query.color_count,
                 p.answer.necklace_count, got.necklace_count);
        errors++;
      end
      if (got.overflow !== p.answer.overflow) begin
        $display("%0t: n=%0d m=%0d overflow expected %0b actual %0b", $time,
                 p.query.pearl_count, p.query.color_count,
                 p.answer.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its signals; every input has a known value from time zero.
  // --------------------------------------------------------------------------
  logic          clk     = 1'b0;
  logic          rst_n   = 1'b0;
  logic          start   = 1'b0;
  ncb_pkg::in_t  in_data = '0;
  logic          busy;
  logic          out_valid;
  ncb_pkg::out_t out_data;

  int unsigned   cycle_count;
  necklace_tally tally;

  necklace_count_burnside #(
    .RESULT_WIDTH(COUNT_WIDTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog: nothing legitimate runs this long.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Result beats: strobe sampled at the edge that closes its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      tally.check_answer(out_data);
  end

  // --------------------------------------------------------------------------
  // Driver tasks. Each query task returns sitting on the edge that accepted its beat,
  // with start still high so a back-to-back beat needs only a data change.
  // --------------------------------------------------------------------------
  task automatic send_query(input logic [7:0] n, input logic [15:0] m,
                            input int unsigned idle_pct);
    int unsigned  gap;
    ncb_pkg::in_t q;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    q.pearl_count = n;
    q.color_count = m;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= q;
    // accept happens at the first edge that sees busy low
    do @(posedge clk); while (busy);
    tally.note_query(q);
  endtask

  // Hold off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (tally.pending_counts.size() != 0);
  endtask

  // Mostly small pearl counts; large n only where it stays cheap (m >= 2
  // saturates within a few dozen steps) or, every 40th beat, the slow m <= 1.
  task automatic random_query(input int unsigned idx, input int unsigned idle_pct);
    logic [7:0]  n;
    logic [15:0] m;
    int unsigned pick;
    pick = $urandom_range(99);
    if (idx % 40 == 39) begin
      n = 8'($urandom_range(255, 128));
      m = 16'($urandom_range(1, 0));
    end else if (pick < 10) begin
      n = 8'd0;
      m = 16'($urandom);
    end else if (pick < 55) begin
      n = 8'($urandom_range(12, 1));
      m = 16'($urandom);
    end else if (pick < 75) begin
      n = 8'($urandom_range(40, 1));
      m = 16'($urandom_range(4, 0));
    end else if (pick < 90) begin
      n = 8'($urandom_range(255, 41));
      // small bases keep n near 64 close to the fit/overflow boundary
      m = (pick < 82) ? 16'($urandom_range(3, 2)) : 16'($urandom_range(65535, 2));
    end else begin
      n = 8'($urandom_range(40, 1));
      m = 16'($urandom_range(1, 0));
    end
    send_query(n, m, idle_pct);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned i;
    int unsigned pct;
    tally = new();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // zero pearls: count 0 whatever the colors
    send_query(8'd0,   16'd0,     27);
    send_query(8'd0,   16'd65535, 27);
    // zero colors with pearls: every power is zero
    send_query(8'd1,   16'd0,     27);
    send_query(8'd40,  16'd0,     27);
    send_query(8'd255, 16'd0,     27);
    // one color: exactly one necklace
    send_query(8'd1,   16'd1,     27);
    send_query(8'd8,   16'd1,     27);
    send_query(8'd255, 16'd1,     27);
    // plain counts
    send_query(8'd1,   16'd65535, 27);
    send_query(8'd6,   16'd3,     27);
    send_query(8'd12,  16'd2,     27);
    send_query(8'd2,   16'd65535, 27);
    send_query(8'd3,   16'd65535, 27);
    // near the top of the range: m^4 fits, m^5 overflows
    send_query(8'd4,   16'd65535, 27);
    send_query(8'd5,   16'd65535, 27);
    // 2^63 plus small terms fits; 2^64 saturates
    send_query(8'd63,  16'd2,     27);
    send_query(8'd64,  16'd2,     27);
    send_query(8'd41,  16'd3,     27);
    send_query(8'd85,  16'd2,     27);
    send_query(8'd255, 16'd2,     27);
    send_query(8'd255, 16'd65535, 27);
    send_query(8'd170, 16'd43690, 27);

    // sender waits out everything in flight before the random part
    drain_results();

    // three phases: sender idles 27%, then 81%, then back-to-back
    for (i = 0; i < 128; i++) begin
      pct = (i < 43) ? 27 : (i < 86) ? 81 : 0;
      random_query(i, pct);
      if (i == 42 || i == 85)
        drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tally.errors == 0 && tally.pending_counts.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
